// ===== rtl/chd_pkg.sv =====
// Shared types and constants for the 4:4:4 to 4:2:0 chroma downsampler.
package chd_pkg;

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Frame geometry
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;

  // Sample and pair-sum widths
  localparam int SMP_W  = 8;
  localparam int PAIR_W = SMP_W + 1;
  localparam int LINE_W = 2 * PAIR_W;

  // Result kinds
  localparam logic KIND_LUMA   = 1'b0;
  localparam logic KIND_CHROMA = 1'b1;

  // Per-pixel work decided at accept time
  typedef struct packed {
    logic              chroma;   // odd row, odd column: emit a chroma beat
    logic              wr;       // even row, odd column: store the pair sum
    logic [PAIR_W-1:0] pair_u;
    logic [PAIR_W-1:0] pair_v;
  } chd_item_t;

endpackage

// ===== rtl/chd_if.sv =====
// Valid/ready channel interfaces for pixel input and result output.
interface chd_pix_if;
  import chd_pkg::*;
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] pix_luma;
  logic [SMP_W-1:0] pix_cb;
  logic [SMP_W-1:0] pix_cr;

  modport source (output valid, output pix_luma, output pix_cb, output pix_cr, input ready);
  modport sink   (input valid, input pix_luma, input pix_cb, input pix_cr, output ready);
endinterface

interface chd_res_if;
  import chd_pkg::*;
  logic             valid;
  logic             ready;
  logic             out_kind;
  logic [SMP_W-1:0] out_luma;
  logic [SMP_W-1:0] out_cb;
  logic [SMP_W-1:0] out_cr;
  logic             out_last;

  modport source (output valid, output out_kind, output out_luma, output out_cb,
                  output out_cr, output out_last, input ready);
  modport sink   (input valid, input out_kind, input out_luma, input out_cb,
                  input out_cr, input out_last, output ready);
endinterface

// ===== rtl/chd_pos.sv =====
// Raster position tracker: row/column counters, left pixel chroma and pair sums.
module chd_pos
  import chd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096,
  parameter int CW        = $clog2(MAX_WIDTH + 1),
  parameter int AW        = ((MAX_WIDTH + 1) / 2 > 1) ? $clog2((MAX_WIDTH + 1) / 2) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [CFG_W-1:0] cfg_width_i,
  input  logic [CFG_W-1:0] cfg_height_i,
  input  logic [SMP_W-1:0] cb_i,
  input  logic [SMP_W-1:0] cr_i,
  output chd_item_t        item_o,
  output logic [AW-1:0]    slot_o
);

  logic [CW-1:0]      col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [2*SMP_W-1:0] left_q, left_d;

  logic [CW-1:0]    w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             col_wrap;
  logic             end_row;
  logic [CW-1:0]    col_a;
  logic [CW:0]      col_n;
  logic [ROW_W:0]   row_b;
  logic [ROW_W:0]   row_c;
  logic [ROW_W:0]   row_n;

  // Clamp geometry to the supported range
  always_comb begin
    if (cfg_width_i == '0) begin
      w_eff = CW'(1);
    end else if ({1'b0, cfg_width_i} > (CFG_W + 1)'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg_width_i);
    end
    if (cfg_height_i == '0) begin
      h_eff = CFG_W'(1);
    end else if (cfg_height_i > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_height_i;
    end
  end

  // Resolve the current position, then advance it past this pixel
  always_comb begin
    col_wrap = (col_q >= w_eff);
    col_a    = col_wrap ? '0 : col_q;
    row_b    = {1'b0, row_q} + {{ROW_W{1'b0}}, col_wrap};
    row_c    = (row_b >= h_eff) ? '0 : row_b;
    col_n    = {1'b0, col_a} + (CW + 1)'(1);
    end_row  = (col_n >= {1'b0, w_eff});
    row_n    = row_c + (ROW_W + 1)'(1);
    if (end_row) begin
      col_d = '0;
      row_d = (row_n >= h_eff) ? '0 : row_n[ROW_W-1:0];
    end else begin
      col_d = col_n[CW-1:0];
      row_d = row_c[ROW_W-1:0];
    end
  end

  // Pair sums and the work for this pixel
  always_comb begin
    left_d        = col_a[0] ? left_q : {cb_i, cr_i};
    item_o.pair_u = {1'b0, left_q[2*SMP_W-1:SMP_W]} + {1'b0, cb_i};
    item_o.pair_v = {1'b0, left_q[SMP_W-1:0]} + {1'b0, cr_i};
    item_o.chroma = col_a[0] & row_c[0];
    item_o.wr     = col_a[0] & ~row_c[0];
    slot_o        = AW'(col_a >> 1);
  end

  // Advance on every accepted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
    end
  end

endmodule

// ===== rtl/chd_line.sv =====
// Line buffer of horizontal U/V pair sums from the even row.
module chd_line
  import chd_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [LINE_W-1:0] wdata_i,
  output logic [LINE_W-1:0] rdata_o
);

  logic [LINE_W-1:0] mem_q [DEPTH];
  logic [LINE_W-1:0] rdata_q;

  // Store a pair sum
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Fetch a pair sum; hold it until the next fetch
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/chd_emit.sv =====
// Result sequencer: holds one pixel and sends its luma beat and optional chroma beat.
module chd_emit
  import chd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [SMP_W-1:0]  luma_i,
  input  chd_item_t         item_i,
  input  logic [LINE_W-1:0] line_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_kind_o,
  output logic [SMP_W-1:0]  out_luma_o,
  output logic [SMP_W-1:0]  out_cb_o,
  output logic [SMP_W-1:0]  out_cr_o,
  output logic              out_last_o
);

  // Pixel stage
  logic              s1_v_q, s1_v_d;
  logic              phase_q, phase_d;
  logic              chroma_q;
  logic [SMP_W-1:0]  luma_q;
  logic [PAIR_W-1:0] su_q;
  logic [PAIR_W-1:0] sv_q;

  // Result register
  logic              ov_q;
  logic              kind_q, kind_d;
  logic [SMP_W-1:0]  oluma_q, oluma_d;
  logic [SMP_W-1:0]  ocb_q, ocb_d;
  logic [SMP_W-1:0]  ocr_q, ocr_d;
  logic              last_q, last_d;

  logic              out_load;
  logic              s1_done;
  logic [PAIR_W:0]   sum_u;
  logic [PAIR_W:0]   sum_v;

  assign out_load   = ~ov_q | out_ready_i;
  assign s1_done    = s1_v_q & out_load & (phase_q | ~chroma_q);
  assign in_ready_o = ~s1_v_q | s1_done;

  // 2x2 totals, divide by four
  assign sum_u = {1'b0, line_i[LINE_W-1:PAIR_W]} + {1'b0, su_q};
  assign sum_v = {1'b0, line_i[PAIR_W-1:0]} + {1'b0, sv_q};

  // Stage occupancy and beat phase
  always_comb begin
    s1_v_d  = s1_v_q;
    phase_d = phase_q;
    if (load_i) begin
      s1_v_d  = 1'b1;
      phase_d = 1'b0;
    end else begin
      if (s1_done) begin
        s1_v_d = 1'b0;
      end
      if (s1_v_q && out_load && !phase_q && chroma_q) begin
        phase_d = 1'b1;
      end
    end
  end

  // Next result beat
  always_comb begin
    if (phase_q) begin
      kind_d  = KIND_CHROMA;
      oluma_d = '0;
      ocb_d   = sum_u[PAIR_W:2];
      ocr_d   = sum_v[PAIR_W:2];
      last_d  = 1'b1;
    end else begin
      kind_d  = KIND_LUMA;
      oluma_d = luma_q;
      ocb_d   = '0;
      ocr_d   = '0;
      last_d  = ~chroma_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      phase_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      phase_q <= phase_d;
      if (out_load) begin
        ov_q <= s1_v_q;
      end
    end
  end

  // Capture the pixel payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      luma_q   <= luma_i;
      chroma_q <= item_i.chroma;
      su_q     <= item_i.pair_u;
      sv_q     <= item_i.pair_v;
    end
  end

  // Advance the result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q  <= kind_d;
      oluma_q <= oluma_d;
      ocb_q   <= ocb_d;
      ocr_q   <= ocr_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = kind_q;
  assign out_luma_o  = oluma_q;
  assign out_cb_o    = ocb_q;
  assign out_cr_o    = ocr_q;
  assign out_last_o  = last_q;

endmodule

// ===== rtl/yuv444_to_nv12_chroma_downsample.sv =====
// Top level of the 4:4:4 to 4:2:0 (NV12 order) chroma downsampler.
//
//   channel   dir  handshake       payload
//   pix_i     in   valid / ready   pix_luma, pix_cb, pix_cr
//   res_o     out  valid / ready   out_kind, out_luma, out_cb, out_cr, out_last
//   cfg       in   cfg_we_i        cfg_idx_i, cfg_data_i (write only)
//
// A pixel stays in the pixel stage until its result beats have entered the
// single result register: a luma beat for a luma-only pixel, a luma and a
// chroma beat for a pixel at an odd column of an odd row. The luma beat is
// registered in the pixel stage and then in the result register.
// The pair-sum line buffer is read at accept and is not cleared by reset.
// Reset returns to row 0, column 0 with 1920x1080 geometry.
// A stalled result register backs up into the pixel stage and then pix_i.ready.
module yuv444_to_nv12_chroma_downsample
  import chd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  chd_pix_if.sink              pix_i,
  chd_res_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int CW         = $clog2(MAX_WIDTH + 1);
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [CFG_W-1:0]  width_q;
  logic [CFG_W-1:0]  height_q;
  logic              accept;
  chd_item_t         item;
  logic [AW-1:0]     slot;
  logic [LINE_W-1:0] line_rd;

  assign accept = pix_i.valid & pix_i.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1920);
      height_q <= CFG_W'(1080);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  chd_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .AW        (AW)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .cb_i         (pix_i.pix_cb),
    .cr_i         (pix_i.pix_cr),
    .item_o       (item),
    .slot_o       (slot)
  );

  chd_line #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line (
    .clk_i   (clk_i),
    .wr_en_i (accept & item.wr),
    .rd_en_i (accept & item.chroma),
    .addr_i  (slot),
    .wdata_i ({item.pair_u, item.pair_v}),
    .rdata_o (line_rd)
  );

  chd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .luma_i      (pix_i.pix_luma),
    .item_i      (item),
    .line_i      (line_rd),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_kind_o  (res_o.out_kind),
    .out_luma_o  (res_o.out_luma),
    .out_cb_o    (res_o.out_cb),
    .out_cr_o    (res_o.out_cr),
    .out_last_o  (res_o.out_last)
  );

  // A luma beat that is not last is followed at once by its chroma beat
  a_chroma_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && res_o.out_kind == KIND_LUMA && !res_o.out_last)
    |=> (res_o.valid && res_o.out_kind == KIND_CHROMA))
    else $error("chroma beat missing after luma beat");

  // Chroma beats always close their pixel and carry no luma
  a_chroma_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.out_kind == KIND_CHROMA)
    |-> (res_o.out_last && res_o.out_luma == '0))
    else $error("malformed chroma beat");

  // A pending result only drops after it was taken
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(res_o.valid) |-> $past(res_o.ready))
    else $error("result beat dropped");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench: drives pixels, predicts luma and 2x2 chroma beats, and checks each one.
module tb;
  import chd_pkg::*;

  localparam int LINE_MAX_W  = 4096;
  localparam int LINE_SLOTS  = LINE_MAX_W / 2;
  localparam int RANDOM_PIX  = 1000;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic             kind;
    logic [SMP_W-1:0] luma;
    logic [SMP_W-1:0] cb;
    logic [SMP_W-1:0] cr;
    logic             is_last;
  } beat_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  chd_pix_if pix_if ();
  chd_res_if res_if ();

  yuv444_to_nv12_chroma_downsample #(
    .MAX_WIDTH(LINE_MAX_W)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_if),
    .res_o     (res_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Downsampler model state: geometry registers, raster position, pair line
  logic [CFG_W-1:0]  geo_w_reg = CFG_W'(1920);
  logic [CFG_W-1:0]  geo_h_reg = CFG_W'(1080);
  int                pos_row = 0;
  int                pos_col = 0;
  logic [SMP_W-1:0]  left_cb = '0;
  logic [SMP_W-1:0]  left_cr = '0;
  logic [LINE_W-1:0] pair_line [LINE_SLOTS];
  bit                pair_written [LINE_SLOTS];
  beat_t             pending_beats [$];

  int n_pixels = 0;
  int n_luma_beats = 0;
  int n_chroma_beats = 0;
  int n_geometries = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;

  function automatic int clamp_dim(logic [CFG_W-1:0] r, int max_dim);
    if (r == 0) return 1;
    if (r > max_dim) return max_dim;
    return int'(r);
  endfunction

  function automatic void next_line(int h);
    pos_col = 0;
    pos_row++;
    if (pos_row >= h) pos_row = 0;
  endfunction

  // Advance the raster position by one pixel and queue the beats it yields
  function automatic void predict_pixel(logic [SMP_W-1:0] y, logic [SMP_W-1:0] cb,
                                        logic [SMP_W-1:0] cr);
    int                w;
    int                h;
    int                slot;
    int                sum_cb;
    int                sum_cr;
    int                tot_cb;
    int                tot_cr;
    logic [LINE_W-1:0] stored;
    beat_t             luma_beat;
    beat_t             chroma_beat;
    bit                chroma;
    w = clamp_dim(geo_w_reg, LINE_MAX_W);
    h = clamp_dim(geo_h_reg, MAX_HEIGHT);
    chroma = 1'b0;
    chroma_beat = '0;
    // Apply a geometry change that left the position outside the frame
    if (pos_col >= w) next_line(h);
    if (pos_row >= h) pos_row = 0;
    if (pos_col % 2 == 0) begin
      left_cb = cb;
      left_cr = cr;
    end else begin
      sum_cb = int'(left_cb) + int'(cb);
      sum_cr = int'(left_cr) + int'(cr);
      slot = pos_col / 2;
      if (pos_row % 2 == 0) begin
        pair_line[slot] = {PAIR_W'(sum_cb), PAIR_W'(sum_cr)};
        pair_written[slot] = 1'b1;
      end else begin
        stored = pair_line[slot];
        tot_cb = int'(stored[LINE_W-1:PAIR_W]) + sum_cb;
        tot_cr = int'(stored[PAIR_W-1:0]) + sum_cr;
        chroma = 1'b1;
        chroma_beat.kind = KIND_CHROMA;
        chroma_beat.cb = SMP_W'(tot_cb >> 2);
        chroma_beat.cr = SMP_W'(tot_cr >> 2);
        chroma_beat.is_last = 1'b1;
      end
    end
    pos_col++;
    if (pos_col >= w) next_line(h);
    luma_beat = '0;
    luma_beat.kind = KIND_LUMA;
    luma_beat.luma = y;
    luma_beat.is_last = !chroma;
    pending_beats.push_back(luma_beat);
    if (chroma) pending_beats.push_back(chroma_beat);
  endfunction

  // True when, under the new geometry, the current odd row reads only written pairs
  function automatic bit geometry_safe(logic [CFG_W-1:0] nw, logic [CFG_W-1:0] nh);
    int w;
    int h;
    int r;
    int c;
    w = clamp_dim(nw, LINE_MAX_W);
    h = clamp_dim(nh, MAX_HEIGHT);
    r = pos_row;
    c = pos_col;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    if (r >= h) r = 0;
    if (r % 2 == 1) begin
      for (int cc = c; cc < w; cc++) begin
        if (cc % 2 == 1 && !pair_written[cc / 2]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SMP_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one pixel beat; open a random gap between bursts
  task automatic send_pixel(input logic [SMP_W-1:0] y, input logic [SMP_W-1:0] cb,
                            input logic [SMP_W-1:0] cr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    predict_pixel(y, cb, cr);
    pix_if.valid    <= 1'b1;
    pix_if.pix_luma <= y;
    pix_if.pix_cb   <= cb;
    pix_if.pix_cr   <= cr;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    n_pixels++;
  endtask

  // Hold the stream until every predicted beat has arrived
  task automatic wait_drain();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  // Pad the current odd row if needed, drain, then write the geometry registers
  task automatic set_geometry(input int w, input int h, input bit wr_w, input bit wr_h);
    logic [CFG_W-1:0] nw;
    logic [CFG_W-1:0] nh;
    nw = wr_w ? CFG_W'(w) : geo_w_reg;
    nh = wr_h ? CFG_W'(h) : geo_h_reg;
    while (!geometry_safe(nw, nh)) send_pixel(rand_sample(), rand_sample(), rand_sample());
    wait_drain();
    if (wr_w) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_FRAME_WIDTH;
      cfg_data_i <= nw;
      @(posedge clk_i);
      geo_w_reg = nw;
    end
    if (wr_h) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_FRAME_HEIGHT;
      cfg_data_i <= nh;
      @(posedge clk_i);
      geo_h_reg = nh;
    end
    cfg_we_i <= 1'b0;
    n_geometries++;
  endtask

  task automatic test_reset_geometry();
    // Reset geometry: two pixels on row 0 store pair slot 0
    send_pixel(8'd0, 8'd10, 8'd200);
    send_pixel(8'd255, 8'd30, 8'd100);
  endtask

  task automatic test_block_average();
    // Narrow to two columns mid-row: row 1 averages against the stored pair
    set_geometry(2, 2, 1'b1, 1'b1);
    send_pixel(8'd17, 8'd50, 8'd60);
    send_pixel(8'd18, 8'd71, 8'd90);
    // Truncated averages: U totals 1019, V totals 3
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd254, 8'd3);
    // Saturated block
    repeat (4) send_pixel(8'd255, 8'd255, 8'd255);
  endtask

  task automatic test_odd_geometry();
    // Odd width and height: the last column and the last row add no chroma
    set_geometry(3, 3, 1'b1, 1'b1);
    for (int i = 0; i < 9; i++) begin
      send_pixel(SMP_W'(i * 29), SMP_W'(255 - i * 13), SMP_W'(i * 31));
    end
  endtask

  task automatic test_geometry_clamp();
    // Zero width and height act as one
    set_geometry(0, 0, 1'b1, 1'b1);
    repeat (2) send_pixel(rand_sample(), rand_sample(), rand_sample());
    // Oversize width acts as the line maximum
    set_geometry(8191, 1, 1'b1, 1'b1);
    repeat (2) send_pixel(rand_sample(), rand_sample(), rand_sample());
    // Widest frame with oversize height
    set_geometry(LINE_MAX_W, 8191, 1'b1, 1'b1);
    repeat (2) send_pixel(rand_sample(), rand_sample(), rand_sample());
    // Shrink to two columns: the position moves to row 1 and averages
    set_geometry(2, 0, 1'b1, 1'b0);
    repeat (2) send_pixel(rand_sample(), rand_sample(), rand_sample());
  endtask

  task automatic test_random_frames();
    int goal;
    int run_len;
    int w;
    int h;
    bit wr_w;
    bit wr_h;
    goal = n_pixels + RANDOM_PIX;
    while (n_pixels < goal) begin
      // Mostly small frames so that odd rows and wraps come often
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          w = $urandom_range(1, 16);
          h = $urandom_range(1, 6);
        end
        6, 7: begin
          w = $urandom_range(17, 80);
          h = $urandom_range(1, 4);
        end
        8: begin
          w = $urandom_range(0, 8191);
          h = $urandom_range(0, 2);
        end
        default: begin
          w = $urandom_range(0, 3);
          h = $urandom_range(0, 8191);
        end
      endcase
      wr_w = ($urandom_range(0, 3) != 0);
      wr_h = !wr_w || ($urandom_range(0, 3) != 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      set_geometry(w, h, wr_w, wr_h);
      run_len = $urandom_range(10, 120);
      repeat (run_len) begin
        send_pixel(rand_sample(), rand_sample(), rand_sample());
        // Now and then hold the stream until everything has drained
        if ($urandom_range(0, 99) == 0) wait_drain();
      end
    end
  endtask

  // Receiver ready pattern, switched among stall styles at random
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  res_if.ready <= 1'b1;
      RX_LIGHT: res_if.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: res_if.ready <= ($urandom_range(0, 3) == 0);
      default:  res_if.ready <= (rx_left % 24 < 8);
    endcase
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (res_if.valid && res_if.ready) begin
      got.kind    = res_if.out_kind;
      got.luma    = res_if.out_luma;
      got.cb      = res_if.out_cb;
      got.cr      = res_if.out_cr;
      got.is_last = res_if.out_last;
      if (pending_beats.size() == 0) begin
        if (n_errors < MAX_REPORTS) begin
          $display("ERROR: unexpected beat kind=%0b luma=%0d cb=%0d cr=%0d last=%0b",
                   got.kind, got.luma, got.cb, got.cr, got.is_last);
        end
        n_errors++;
      end else begin
        want = pending_beats.pop_front();
        if (want.kind == KIND_CHROMA) n_chroma_beats++;
        else n_luma_beats++;
        if (got.kind !== want.kind || got.luma !== want.luma || got.cb !== want.cb ||
            got.cr !== want.cr || got.is_last !== want.is_last) begin
          if (n_errors < MAX_REPORTS) begin
            $display("ERROR: beat mismatch exp kind=%0b luma=%0d cb=%0d cr=%0d last=%0b",
                     want.kind, want.luma, want.cb, want.cr, want.is_last);
            $display("                    got kind=%0b luma=%0d cb=%0d cr=%0d last=%0b",
                     got.kind, got.luma, got.cb, got.cr, got.is_last);
          end
          n_errors++;
        end
      end
    end
  end

  // End the run when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_FRAME_WIDTH;
    cfg_data_i      <= '0;
    pix_if.valid    <= 1'b0;
    pix_if.pix_luma <= '0;
    pix_if.pix_cb   <= '0;
    pix_if.pix_cr   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_block_average();
    test_odd_geometry();
    test_geometry_clamp();
    test_random_frames();

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d pixels; checked %0d luma and %0d chroma beats",
             n_pixels, n_luma_beats, n_chroma_beats);
    $display("Applied %0d frame geometries, clamped, odd-sized and mid-frame changes included",
             n_geometries);
    if (n_errors == 0 && pending_beats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
